@@ sv/upd_pkg.sv @@
package upd_pkg;

   localparam int INTERVAL_BITS = 17;
   localparam int WIDTH_BITS    = 15;
   localparam int TRIGGER_BITS  = 8;
   localparam int HITS_BITS     = 3;
   localparam int ADDR_BITS     = 5;
   localparam int DATA_BITS     = 32;

   // Register indexes, taken from paddr[4:2].
   localparam logic [2:0] REG_INTERVAL = 3'd0;
   localparam logic [2:0] REG_TRIGGER  = 3'd1;
   localparam logic [2:0] REG_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_LOW_ECHO = 3'd3;
   localparam logic [2:0] REG_HIGH_ECHO = 3'd4;
   localparam logic [2:0] REG_HITS     = 3'd5;

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(101000);
   localparam logic [TRIGGER_BITS-1:0]  TRIGGER_RESET  = TRIGGER_BITS'(10);
   localparam logic [WIDTH_BITS-1:0]    TIMEOUT_RESET  = WIDTH_BITS'(25000);
   localparam logic [WIDTH_BITS-1:0]    LOW_ECHO_RESET = WIDTH_BITS'(1177);
   localparam logic [WIDTH_BITS-1:0]    HIGH_ECHO_RESET = WIDTH_BITS'(2352);
   localparam logic [HITS_BITS-1:0]     HITS_RESET     = HITS_BITS'(3);

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_TRIG = 3'd1,
      PH_PRE  = 3'd2,
      PH_RISE = 3'd3,
      PH_HIGH = 3'd4
   } phase_type;

endpackage

@@ sv/ultrasonic_presence_detector.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_echo_level
// rsp       out        rsp_valid / rsp_ready  rsp_trigger_level, rsp_detected,
//                                             rsp_measure_done, rsp_echo_width
// csr       in         psel / penable / pready  paddr, pwdata, prdata
//
// One item is accepted per cycle while the result register is free or being taken;
// each item passes from the input register into the result register.
// The whole tick update is one pass of logic between those two registers.
// Reset clears all control state and loads the register defaults.
// A stalled result holds in the result register; one more item waits in the
// input register, after which req_ready drops until rsp_ready returns.
module ultrasonic_presence_detector
   import upd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_echo_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_trigger_level,
   output logic                  rsp_detected,
   output logic                  rsp_measure_done,
   output logic [WIDTH_BITS-1:0] rsp_echo_width,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   localparam logic [INTERVAL_BITS-1:0] IMAX = '1;
   localparam logic [WIDTH_BITS-1:0]    WMAX = '1;

   // Configuration registers.
   logic [INTERVAL_BITS-1:0] interval_ff;
   logic [TRIGGER_BITS-1:0]  trigger_ff;
   logic [WIDTH_BITS-1:0]    timeout_ff;
   logic [WIDTH_BITS-1:0]    low_echo_ff;
   logic [WIDTH_BITS-1:0]    high_echo_ff;
   logic [HITS_BITS-1:0]     hits_ff;
   logic                     csr_write;
   logic [2:0]               csr_index;

   // Pipeline control.
   logic in_valid_ff, in_valid_in;
   logic echo_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic move;

   // Measurement state.
   phase_type                phase_ff, phase_in;
   logic [INTERVAL_BITS-1:0] interval_count_ff, interval_count_in;
   logic [WIDTH_BITS-1:0]    phase_count_ff, phase_count_in;
   logic [WIDTH_BITS-1:0]    width_count_ff, width_count_in;
   logic [HITS_BITS-1:0]     hit_count_ff, hit_count_in;
   logic [WIDTH_BITS-1:0]    last_width_ff, last_width_in;
   logic                     trigger_out_ff, trigger_out_in;
   logic                     detected_ff, detected_in;
   logic                     done_ff, done_in;

   // Step logic.
   logic [INTERVAL_BITS-1:0] ivl;
   logic [TRIGGER_BITS-1:0]  tlen;
   logic [HITS_BITS-1:0]     need;
   logic [INTERVAL_BITS:0]   interval_next;
   logic                     start;
   logic                     trig_go;
   phase_type                echo_phase;
   logic                     echo_active;
   logic [WIDTH_BITS-1:0]    pc_base;
   logic [WIDTH_BITS:0]      elapsed;
   logic                     ended;
   logic                     timed_out;
   logic                     finished;
   logic [WIDTH_BITS-1:0]    finish_width;
   logic                     hit;
   logic [HITS_BITS-1:0]     hit_plus;
   logic                     det;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RESET;
         trigger_ff   <= TRIGGER_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         low_echo_ff  <= LOW_ECHO_RESET;
         high_echo_ff <= HIGH_ECHO_RESET;
         hits_ff      <= HITS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_INTERVAL:  interval_ff  <= pwdata[INTERVAL_BITS-1:0];
            REG_TRIGGER:   trigger_ff   <= pwdata[TRIGGER_BITS-1:0];
            REG_TIMEOUT:   timeout_ff   <= pwdata[WIDTH_BITS-1:0];
            REG_LOW_ECHO:  low_echo_ff  <= pwdata[WIDTH_BITS-1:0];
            REG_HIGH_ECHO: high_echo_ff <= pwdata[WIDTH_BITS-1:0];
            REG_HITS:      hits_ff      <= pwdata[HITS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_INTERVAL:  prdata = DATA_BITS'(interval_ff);
         REG_TRIGGER:   prdata = DATA_BITS'(trigger_ff);
         REG_TIMEOUT:   prdata = DATA_BITS'(timeout_ff);
         REG_LOW_ECHO:  prdata = DATA_BITS'(low_echo_ff);
         REG_HIGH_ECHO: prdata = DATA_BITS'(high_echo_ff);
         REG_HITS:      prdata = DATA_BITS'(hits_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign move      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         echo_ff <= req_echo_level;
      end
   end

   // ---------------------------------------------------------------- step flags
   // Zero-valued interval, trigger and hits registers behave as one.
   assign ivl  = (interval_ff == '0) ? INTERVAL_BITS'(1) : interval_ff;
   assign tlen = (trigger_ff == '0) ? TRIGGER_BITS'(1) : trigger_ff;
   assign need = (hits_ff == '0) ? HITS_BITS'(1) : hits_ff;

   assign interval_next = {1'b0, interval_count_ff} + (INTERVAL_BITS+1)'(1);
   assign start   = (phase_ff == PH_WAIT) && (interval_next >= {1'b0, ivl});
   assign trig_go = (phase_ff == PH_TRIG) && (phase_count_ff < WIDTH_BITS'(tlen));

   // The tick on which the trigger drops is already the first tick of the echo wait.
   assign echo_phase  = (phase_ff == PH_TRIG && !trig_go) ? PH_PRE : phase_ff;
   assign echo_active = !start && (echo_phase == PH_PRE || echo_phase == PH_RISE ||
                                   echo_phase == PH_HIGH);
   assign pc_base     = (phase_ff == PH_TRIG) ? '0 : phase_count_ff;
   assign elapsed     = {1'b0, pc_base} + (WIDTH_BITS+1)'(1);

   // A falling echo wins over a timeout on the same tick.
   assign ended     = echo_active && (echo_phase == PH_HIGH) && !echo_ff;
   assign timed_out = echo_active && !ended && (elapsed >= {1'b0, timeout_ff});
   assign finished  = ended || timed_out;

   // ---------------------------------------------------------------- next phase
   always_comb begin
      phase_in = phase_ff;
      if (start || trig_go) begin
         phase_in = PH_TRIG;
      end else if (finished) begin
         phase_in = PH_WAIT;
      end else begin
         unique case (echo_phase)
            PH_WAIT: phase_in = PH_WAIT;
            PH_TRIG: phase_in = PH_WAIT;
            PH_PRE:  phase_in = echo_ff ? PH_PRE : PH_RISE;
            PH_RISE: phase_in = echo_ff ? PH_HIGH : PH_RISE;
            PH_HIGH: phase_in = PH_HIGH;
            default: phase_in = PH_WAIT;
         endcase
      end
   end

   // ---------------------------------------------------------------- counters and outputs
   always_comb begin
      interval_count_in = interval_count_ff;
      phase_count_in    = phase_count_ff;
      width_count_in    = width_count_ff;
      finish_width      = ended ? width_count_ff : '0;
      hit_plus          = hit_count_ff + HITS_BITS'(1);
      hit               = ended && (finish_width >= low_echo_ff) &&
                          (finish_width <= high_echo_ff);
      det               = hit && (hit_plus >= need);
      hit_count_in      = hit_count_ff;
      last_width_in     = last_width_ff;

      if (start) begin
         interval_count_in = '0;
         phase_count_in    = WIDTH_BITS'(1);
      end else begin
         if (interval_count_ff != IMAX) begin
            interval_count_in = interval_count_ff + INTERVAL_BITS'(1);
         end
         if (trig_go) begin
            phase_count_in = phase_count_ff + WIDTH_BITS'(1);
         end else if (phase_ff == PH_TRIG) begin
            phase_count_in = '0;
            width_count_in = '0;
         end
         if (echo_active) begin
            if (echo_phase == PH_RISE && echo_ff) begin
               width_count_in = WIDTH_BITS'(1);
            end else if (echo_phase == PH_HIGH && echo_ff && width_count_ff != WMAX) begin
               width_count_in = width_count_ff + WIDTH_BITS'(1);
            end
            if (!finished) begin
               phase_count_in = elapsed[WIDTH_BITS-1:0];
            end
         end
      end

      if (finished) begin
         last_width_in = finish_width;
         if (hit) begin
            hit_count_in = det ? '0 : hit_plus;
         end else begin
            hit_count_in = '0;
         end
      end

      trigger_out_in = start || trig_go;
      detected_in    = finished && det;
      done_in        = finished;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_WAIT;
         interval_count_ff <= '0;
         phase_count_ff    <= '0;
         width_count_ff    <= '0;
         hit_count_ff      <= '0;
         last_width_ff     <= '0;
      end else if (move) begin
         phase_ff          <= phase_in;
         interval_count_ff <= interval_count_in;
         phase_count_ff    <= phase_count_in;
         width_count_ff    <= width_count_in;
         hit_count_ff      <= hit_count_in;
         last_width_ff     <= last_width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         trigger_out_ff <= trigger_out_in;
         detected_ff    <= detected_in;
         done_ff        <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = trigger_out_ff;
   assign rsp_detected      = detected_ff;
   assign rsp_measure_done  = done_ff;
   assign rsp_echo_width    = last_width_ff;

endmodule

@@ sv/upd_checker.sv @@
module upd_checker
   import upd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_trigger_level,
   input logic                  rsp_detected,
   input logic                  rsp_measure_done,
   input logic [WIDTH_BITS-1:0] rsp_echo_width
);

   // The result channel is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_width) &&
      $stable(rsp_detected) && $stable(rsp_measure_done) && $stable(rsp_trigger_level))
      else $error("stalled result item changed");

   // Presence is only reported on the tick that ends a measurement.
   a_det_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected |-> rsp_measure_done)
      else $error("detected without measure_done");

   // The trigger is never driven on the tick a measurement ends.
   a_trig_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger_level |-> !rsp_measure_done)
      else $error("trigger high on a measurement end");

   // A timeout reports a zero width and is always a miss.
   a_timeout_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_measure_done && rsp_echo_width == '0 |-> !rsp_detected)
      else $error("detected on a timed-out measurement");

endmodule

bind ultrasonic_presence_detector upd_checker u_upd_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import upd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [INTERVAL_BITS-1:0] interval;
      logic [TRIGGER_BITS-1:0]  trigger;
      logic [WIDTH_BITS-1:0]    timeout;
      logic [WIDTH_BITS-1:0]    low;
      logic [WIDTH_BITS-1:0]    high;
      logic [HITS_BITS-1:0]     hits;
   } settings_type;

   typedef struct {
      phase_type                phase;
      logic [INTERVAL_BITS-1:0] ivl_cnt;
      logic [WIDTH_BITS-1:0]    ph_cnt;
      logic [WIDTH_BITS-1:0]    width_cnt;
      logic [WIDTH_BITS-1:0]    last_width;
      logic [HITS_BITS-1:0]     hit_cnt;
   } sonar_state_type;

   typedef struct {
      logic                  trig;
      logic                  det;
      logic                  done;
      logic [WIDTH_BITS-1:0] width;
   } tick_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_echo_level = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic                  rsp_trigger_level;
   logic                  rsp_detected;
   logic                  rsp_measure_done;
   logic [WIDTH_BITS-1:0] rsp_echo_width;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_BITS-1:0]  paddr = '0;
   logic [DATA_BITS-1:0]  pwdata = '0;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   settings_type    cfg_now;
   sonar_state_type gen_state, chk_state;
   tick_result_type predicted, want;
   logic            echo_queue[$];
   tick_result_type expected_q[$];

   int  items_made = 0;
   int  items_checked = 0;
   int  errors = 0;
   int  cycle_count = 0;
   int  settings_count = 0;
   int  measure_count = 0;
   int  detect_count = 0;
   bit  req_taken = 1'b0;
   int  send_burst = 20;
   int  send_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  stall_style = 0;

   // Echo plan for the measurement the stimulus is currently shaping.
   int  plan_pre, plan_gap, plan_width, plan_pos;
   bit  plan_noise;

   ultrasonic_presence_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_level    (req_echo_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_detected      (rsp_detected),
      .rsp_measure_done  (rsp_measure_done),
      .rsp_echo_width    (rsp_echo_width),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #1 clock = ~clock;

   function automatic sonar_state_type sonar_cleared();
      sonar_state_type s;
      s.phase      = PH_WAIT;
      s.ivl_cnt    = '0;
      s.ph_cnt     = '0;
      s.width_cnt  = '0;
      s.last_width = '0;
      s.hit_cnt    = '0;
      return s;
   endfunction

   function automatic logic [31:0] reg_field(settings_type c, logic [2:0] idx);
      case (idx)
         REG_INTERVAL:  return 32'(c.interval);
         REG_TRIGGER:   return 32'(c.trigger);
         REG_TIMEOUT:   return 32'(c.timeout);
         REG_LOW_ECHO:  return 32'(c.low);
         REG_HIGH_ECHO: return 32'(c.high);
         default:       return 32'(c.hits);
      endcase
   endfunction

   // One microsecond tick of the ranging controller.
   function automatic tick_result_type sonar_tick(inout sonar_state_type s, input logic echo);
      tick_result_type r;
      int ivl, tlen, need, elapsed;
      logic ended;
      r.trig = 1'b0;
      r.det  = 1'b0;
      r.done = 1'b0;
      ended  = 1'b0;
      ivl  = (cfg_now.interval == 0) ? 1 : int'(cfg_now.interval);
      tlen = (cfg_now.trigger == 0) ? 1 : int'(cfg_now.trigger);
      need = (cfg_now.hits == 0) ? 1 : int'(cfg_now.hits);
      if (s.phase == PH_WAIT && int'(s.ivl_cnt) + 1 >= ivl) begin
         s.ivl_cnt = '0;
         s.phase   = PH_TRIG;
         s.ph_cnt  = WIDTH_BITS'(1);
         r.trig    = 1'b1;
      end else begin
         if (s.ivl_cnt != '1) s.ivl_cnt = s.ivl_cnt + 1'b1;
         if (s.phase == PH_TRIG) begin
            if (int'(s.ph_cnt) < tlen) begin
               r.trig   = 1'b1;
               s.ph_cnt = s.ph_cnt + 1'b1;
            end else begin
               // The tick on which the trigger drops already samples the echo.
               s.phase     = PH_PRE;
               s.ph_cnt    = '0;
               s.width_cnt = '0;
            end
         end
         if (s.phase inside {PH_PRE, PH_RISE, PH_HIGH}) begin
            elapsed = int'(s.ph_cnt) + 1;
            case (s.phase)
               PH_PRE: begin
                  if (!echo) s.phase = PH_RISE;
               end
               PH_RISE: begin
                  if (echo) begin
                     s.phase     = PH_HIGH;
                     s.width_cnt = WIDTH_BITS'(1);
                  end
               end
               default: begin
                  if (!echo) ended = 1'b1;
                  else if (s.width_cnt != '1) s.width_cnt = s.width_cnt + 1'b1;
               end
            endcase
            // A falling echo wins over a timeout on the same tick.
            if (ended || elapsed >= int'(cfg_now.timeout)) begin
               r.done       = 1'b1;
               s.phase      = PH_WAIT;
               s.last_width = ended ? s.width_cnt : '0;
               if (ended && s.width_cnt >= cfg_now.low && s.width_cnt <= cfg_now.high) begin
                  s.hit_cnt = s.hit_cnt + 1'b1;
                  if (int'(s.hit_cnt) >= need) begin
                     r.det     = 1'b1;
                     s.hit_cnt = '0;
                  end
               end else begin
                  s.hit_cnt = '0;
               end
            end else begin
               s.ph_cnt = elapsed[WIDTH_BITS-1:0];
            end
         end
      end
      r.width = s.last_width;
      return r;
   endfunction

   function automatic settings_type random_settings();
      settings_type c;
      c.interval = INTERVAL_BITS'($urandom_range(6, 40));
      c.trigger  = TRIGGER_BITS'($urandom_range(1, 5));
      c.timeout  = WIDTH_BITS'($urandom_range(8, 50));
      c.low      = WIDTH_BITS'($urandom_range(1, int'(c.timeout) / 3));
      c.high     = c.low + WIDTH_BITS'($urandom_range(0, 10));
      c.hits     = HITS_BITS'($urandom_range(1, 3));
      case ($urandom_range(0, 9))
         0: c.interval = '0;
         1: c.trigger = '0;
         2: c.timeout = WIDTH_BITS'($urandom_range(0, 3));
         3: c.high = c.low - 1'b1;
         4: c.hits = '0;
         5: c.low = '0;
         6: c.interval = INTERVAL_BITS'($urandom_range(1, 4));
         7: c.hits = HITS_BITS'(7);
         default: ;
      endcase
      return c;
   endfunction

   task automatic csr_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_BITS'({idx, 2'b00});
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Waits until the block is idle, then writes and reads back every register.
   task automatic load_settings(input settings_type c);
      logic [31:0] back;
      logic [2:0]  idx;
      int i;
      wait (items_checked >= items_made);
      repeat (4) @(posedge clock);
      for (i = 0; i < 6; i++) begin
         idx = i[2:0];
         csr_access(1'b1, idx, reg_field(c, idx), back);
         csr_access(1'b0, idx, '0, back);
         if (back !== reg_field(c, idx)) begin
            $error("register %0d readback: expected %0d, got %0d", idx, reg_field(c, idx), back);
            errors++;
         end
      end
      cfg_now = c;
      settings_count++;
   endtask

   task automatic push_echo(input logic e);
      void'(sonar_tick(gen_state, e));
      echo_queue.push_back(e);
      items_made++;
   endtask

   // Echo follows a sensor-like plan per measurement: optional echo already high,
   // a low gap, then a pulse whose width is chosen around the hit window, or random noise.
   task automatic push_planned(input int n);
      int k, tlen, lo, hi, tmo;
      logic e;
      for (k = 0; k < n; k++) begin
         tlen = (cfg_now.trigger == 0) ? 1 : int'(cfg_now.trigger);
         if (gen_state.phase inside {PH_PRE, PH_RISE, PH_HIGH} ||
             (gen_state.phase == PH_TRIG && int'(gen_state.ph_cnt) >= tlen)) begin
            if (plan_noise) e = 1'($urandom_range(0, 1));
            else if (plan_pos < plan_pre) e = 1'b1;
            else if (plan_pos < plan_pre + plan_gap) e = 1'b0;
            else e = (plan_pos < plan_pre + plan_gap + plan_width);
            plan_pos++;
         end else begin
            if (gen_state.phase == PH_WAIT) begin
               lo  = (cfg_now.low == 0) ? 1 : int'(cfg_now.low);
               hi  = int'(cfg_now.high);
               tmo = int'(cfg_now.timeout);
               plan_pos   = 0;
               plan_noise = 1'b0;
               plan_pre   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
               plan_gap   = $urandom_range(1, 4);
               plan_width = $urandom_range(1, tmo + 1);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: begin
                     if (lo <= hi) plan_width = $urandom_range(lo, (hi < lo + 60) ? hi : lo + 60);
                  end
                  4, 5: begin
                     case ($urandom_range(0, 3))
                        0: plan_width = lo - 1;
                        1: plan_width = lo;
                        2: plan_width = hi;
                        default: plan_width = hi + 1;
                     endcase
                  end
                  6: plan_width = tmo - plan_pre - plan_gap - 1;
                  7: plan_width = tmo + 2;
                  8: plan_gap = tmo + 5;
                  default: plan_noise = 1'b1;
               endcase
               if (plan_width < 1) plan_width = 1;
            end
            e = 1'($urandom_range(0, 1));
         end
         push_echo(e);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (echo_queue.size() > 0) begin
            req_valid      <= 1'b1;
            req_echo_level <= echo_queue.pop_front();
            send_burst--;
            if (send_burst <= 0) begin
               send_burst = $urandom_range(1, 40);
               send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: one long hold-off mid-run, otherwise a changing stall pattern.
   always @(negedge clock) begin
      if (cycle_count % 50 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && items_checked >= 900) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (cycle_count % 4 != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run exceeded %0d cycles", CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else if (!reset) begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            predicted = sonar_tick(chk_state, req_echo_level);
            expected_q.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            items_checked++;
            if (expected_q.size() == 0) begin
               $error("result item arrived with no tick pending");
               errors++;
            end else begin
               want = expected_q.pop_front();
               measure_count += want.done;
               detect_count  += want.det;
               if (rsp_trigger_level !== want.trig) begin
                  $error("trigger_level: expected %0d, got %0d", want.trig, rsp_trigger_level);
                  errors++;
               end
               if (rsp_detected !== want.det) begin
                  $error("detected: expected %0d, got %0d", want.det, rsp_detected);
                  errors++;
               end
               if (rsp_measure_done !== want.done) begin
                  $error("measure_done: expected %0d, got %0d", want.done, rsp_measure_done);
                  errors++;
               end
               if (rsp_echo_width !== want.width) begin
                  $error("echo_width: expected %0d, got %0d", want.width, rsp_echo_width);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      settings_type c;
      logic [31:0]  back;
      logic [15:0]  short_pattern;
      int i;
      cfg_now.interval = INTERVAL_RESET;
      cfg_now.trigger  = TRIGGER_RESET;
      cfg_now.timeout  = TIMEOUT_RESET;
      cfg_now.low      = LOW_ECHO_RESET;
      cfg_now.high     = HIGH_ECHO_RESET;
      cfg_now.hits     = HITS_RESET;
      gen_state = sonar_cleared();
      chk_state = sonar_cleared();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < 6; i++) begin
         csr_access(1'b0, i[2:0], '0, back);
         if (back !== reg_field(cfg_now, i[2:0])) begin
            $error("register %0d after reset: expected %0d, got %0d",
                   i, reg_field(cfg_now, i[2:0]), back);
            errors++;
         end
      end
      push_planned(8);

      // Every register at zero: each one must act as its smallest useful value.
      c = '{interval: '0, trigger: '0, timeout: '0, low: '0, high: '0, hits: '0};
      load_settings(c);
      push_echo(1'b1);
      push_echo(1'b0);
      push_echo(1'b1);
      push_echo(1'b1);
      push_echo(1'b0);
      push_echo(1'b0);

      // Back-to-back short measurements: echo already high, echo ending on the
      // timeout tick, and single-tick pulses.
      c = '{interval: INTERVAL_BITS'(1), trigger: TRIGGER_BITS'(1),
            timeout: WIDTH_BITS'(4), low: WIDTH_BITS'(1), high: WIDTH_BITS'(2),
            hits: HITS_BITS'(1)};
      load_settings(c);
      short_pattern = 16'b1111_0001_0110_0100;
      for (i = 0; i < 16; i++) push_echo(short_pattern[i]);

      for (i = 0; i < 6; i++) begin
         load_settings(random_settings());
         push_planned(100);
      end
      c = '{interval: INTERVAL_BITS'(300), trigger: TRIGGER_BITS'(255),
            timeout: WIDTH_BITS'(40), low: WIDTH_BITS'(3), high: WIDTH_BITS'(20),
            hits: HITS_BITS'(1)};
      load_settings(c);
      push_planned(300);
      for (i = 0; i < 6; i++) begin
         load_settings(random_settings());
         push_planned(100);
      end
      c = '{interval: INTERVAL_BITS'(60), trigger: TRIGGER_BITS'(2),
            timeout: WIDTH_BITS'(32767), low: '0, high: WIDTH_BITS'(32767),
            hits: HITS_BITS'(2)};
      load_settings(c);
      push_planned(120);
      c = '{interval: INTERVAL_BITS'(131071), trigger: TRIGGER_BITS'(255),
            timeout: WIDTH_BITS'(32767), low: WIDTH_BITS'(32767),
            high: WIDTH_BITS'(32767), hits: HITS_BITS'(7)};
      load_settings(c);
      push_planned(40);
      load_settings(random_settings());
      push_planned(60);

      wait (items_checked >= items_made);
      repeat (10) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d expected result items never arrived", expected_q.size());
         errors++;
      end
      $display("Checked %0d ticks under %0d register settings in %0d cycles.",
               items_checked, settings_count, cycle_count);
      $display("Measurements ended: %0d, presence reports: %0d.", measure_count, detect_count);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
